### src/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// shared types and constants of the first-fit chunk allocator
// ----------------------------------------------------------------------------
package ffca_pkg;

    localparam int MaxChunks   = 64;
    localparam int HeaderBytes = 16;
    localparam int AddrBits    = 32;
    localparam int IdxBits     = $clog2(MaxChunks);
    localparam int LinkBits    = IdxBits + 1;
    localparam int CntBits     = $clog2(MaxChunks + 1);

    localparam logic [LinkBits-1:0] NoneMark = LinkBits'(MaxChunks);

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_FREE    = 2'd2,
        OP_REALLOC = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_FULL    = 3'd3,
        ST_SMALL   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOT,
        S_ADD,
        S_FIND_RD,
        S_FIND_CHK,
        S_FIT_RD,
        S_FIT_CHK,
        S_SPLIT,
        S_DONE
    } state_t;

endpackage

### src/first_fit_chunk_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_chunk_allocator_core
// first-fit allocator over a linked chunk list held in memories
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                          tuser
//  s_       in   opcode[1:0] address[33:2] amount[65:34]     -
//  m_       out  result_address[31:0] copy_length[63:32]     -
//                status[66:64]
//
//  one item at a time; a list walk reads each chunk visited from memory
//  then compares it, and the free slot search steps one slot at a time
//  worst case is a reallocate: slot search, address walk over the
//  whole list, then a failed fit walk
//  s_tready is high only in idle; the result register holds until m_tready
//  aresetn clears valid bits and list head and tail; no clearing pass
// ----------------------------------------------------------------------------
module first_fit_chunk_allocator_core
    import ffca_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // opcode, address, amount
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata    // result_address, copy_length, status
);

    logic [AddrBits-1:0] addr_mem [MaxChunks];
    logic [31:0]         size_mem [MaxChunks];
    logic                used_mem [MaxChunks];
    logic [LinkBits-1:0] succ_mem [MaxChunks];
    logic [MaxChunks-1:0] valid_reg;

    state_t              state_reg, state_next;
    opcode_t             op_reg;
    logic [31:0]         in_addr_reg, amount_reg;
    logic [LinkBits-1:0] head_reg, tail_reg, cur_reg, slot_reg, fit_reg;
    logic [CntBits-1:0]  cnt_reg;
    logic [31:0]         old_size_reg;
    logic                realloc_reg;
    logic [31:0]         res_addr_reg, copy_reg;
    status_t             status_reg;
    logic                m_valid_reg;

    // registered read port
    logic [AddrBits-1:0] rd_addr;
    logic [31:0]         rd_size;
    logic                rd_used;
    logic [LinkBits-1:0] rd_succ;

    logic [IdxBits-1:0] cur_idx, slot_idx, fit_idx, tail_idx;
    logic cur_live, tail_live, head_live;
    logic [31:0] rest;
    logic slot_busy, walk_ok, addr_hit, chunk_fits, alloc_path;

    assign cur_idx  = cur_reg[IdxBits-1:0];
    assign slot_idx = slot_reg[IdxBits-1:0];
    assign fit_idx  = fit_reg[IdxBits-1:0];
    assign tail_idx = tail_reg[IdxBits-1:0];
    assign cur_live  = (cur_reg < NoneMark) && valid_reg[cur_idx];
    assign tail_live = (tail_reg < NoneMark) && valid_reg[tail_idx];
    assign head_live = (head_reg < NoneMark) && valid_reg[head_reg[IdxBits-1:0]];
    assign rest = rd_size - amount_reg;

    assign slot_busy  = (slot_reg < NoneMark) && valid_reg[slot_idx];
    assign walk_ok    = (cnt_reg < CntBits'(MaxChunks)) && cur_live;
    assign addr_hit   = (rd_addr == in_addr_reg);
    assign chunk_fits = !rd_used && (rd_size >= amount_reg);
    assign alloc_path = (op_reg == OP_ALLOC) ||
                        (op_reg == OP_REALLOC && in_addr_reg == '0);

    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, status_reg, copy_reg, res_addr_reg};

    always_ff @(posedge aclk) begin
        rd_addr <= addr_mem[cur_idx];
        rd_size <= size_mem[cur_idx];
        rd_used <= used_mem[cur_idx];
        rd_succ <= succ_mem[cur_idx];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) state_next = S_SLOT;
            end
            S_SLOT: begin
                if (slot_busy)              state_next = S_SLOT;
                else if (op_reg == OP_ADD)  state_next = S_ADD;
                else if (alloc_path)        state_next = S_FIT_RD;
                else                        state_next = S_FIND_RD;
            end
            S_ADD:      state_next = S_DONE;
            S_FIND_RD:  state_next = walk_ok ? S_FIND_CHK : S_DONE;
            S_FIND_CHK: begin
                if (!addr_hit)              state_next = S_FIND_RD;
                else if (op_reg == OP_FREE) state_next = S_DONE;
                else                        state_next = S_FIT_RD;
            end
            S_FIT_RD:   state_next = walk_ok ? S_FIT_CHK : S_DONE;
            S_FIT_CHK:  state_next = chunk_fits ? S_SPLIT : S_FIT_RD;
            S_SPLIT:    state_next = S_DONE;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            head_reg    <= NoneMark;
            tail_reg    <= NoneMark;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        op_reg       <= opcode_t'(s_tdata[1:0]);
                        in_addr_reg  <= s_tdata[33:2];
                        amount_reg   <= s_tdata[65:34];
                        slot_reg     <= '0;
                        cur_reg      <= head_reg;
                        cnt_reg      <= '0;
                        res_addr_reg <= '0;
                        copy_reg     <= '0;
                        status_reg   <= ST_OK;
                        realloc_reg  <= 1'b0;
                    end
                end
                S_SLOT: begin
                    // find the lowest free slot, one per cycle
                    if (slot_busy) begin
                        slot_reg <= slot_reg + 1'b1;
                    end
                end
                S_ADD: begin
                    if (amount_reg <= 32'(HeaderBytes)) begin
                        status_reg <= ST_SMALL;
                    end else if (slot_reg == NoneMark) begin
                        status_reg <= ST_FULL;
                    end else begin
                        valid_reg[slot_idx] <= 1'b1;
                        used_mem[slot_idx]  <= 1'b0;
                        size_mem[slot_idx]  <= amount_reg - 32'(HeaderBytes);
                        addr_mem[slot_idx]  <= in_addr_reg + 32'(HeaderBytes);
                        succ_mem[slot_idx]  <= NoneMark;
                        if (tail_live && head_live)
                            succ_mem[tail_idx] <= slot_reg;
                        else
                            head_reg <= slot_reg;
                        tail_reg <= slot_reg;
                    end
                end
                S_FIND_RD: begin
                    if (!walk_ok)
                        status_reg <= ST_UNKNOWN;
                end
                S_FIND_CHK: begin
                    if (addr_hit) begin
                        if (op_reg == OP_FREE) begin
                            used_mem[cur_idx] <= 1'b0;
                        end else begin
                            old_size_reg <= rd_size;
                            realloc_reg  <= 1'b1;
                            cur_reg      <= head_reg;
                            cnt_reg      <= '0;
                        end
                    end else begin
                        cur_reg   <= rd_succ;
                        cnt_reg   <= cnt_reg + 1'b1;
                    end
                end
                S_FIT_RD: begin
                    if (!walk_ok)
                        status_reg <= ST_NOFIT;
                end
                S_FIT_CHK: begin
                    if (chunk_fits) begin
                        fit_reg   <= cur_reg;
                        used_mem[cur_idx] <= 1'b1;
                        res_addr_reg <= rd_addr;
                        if (realloc_reg)
                            copy_reg <= (amount_reg < old_size_reg) ? amount_reg
                                                                    : old_size_reg;
                    end else begin
                        cur_reg   <= rd_succ;
                        cnt_reg   <= cnt_reg + 1'b1;
                    end
                end
                S_SPLIT: begin
                    // rd_* still holds the fitted chunk
                    if (rest > 32'(HeaderBytes) && slot_reg != NoneMark) begin
                        valid_reg[slot_idx] <= 1'b1;
                        used_mem[slot_idx]  <= 1'b0;
                        size_mem[slot_idx]  <= rest - 32'(HeaderBytes);
                        addr_mem[slot_idx]  <= rd_addr + amount_reg + 32'(HeaderBytes);
                        succ_mem[slot_idx]  <= rd_succ;
                        succ_mem[fit_idx]   <= slot_reg;
                        size_mem[fit_idx]   <= amount_reg;
                        if (tail_reg == fit_reg) tail_reg <= slot_reg;
                    end
                end
                S_DONE: begin
                    m_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_done_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE |=> m_tvalid) else $error("result not raised");
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status_reg != ST_OK |-> res_addr_reg == '0 && copy_reg == '0)
        else $error("failure carries data");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
`endif

endmodule
